FILE: rtl/nsq_pkg.sv
// Shared constants and types for the note scale quantiser.
package nsq_pkg;

    localparam int HELD_ENTRIES = 64;

    localparam int PITCH_W = 7;
    localparam int VEL_W   = 7;
    localparam int ID_W    = 16;
    localparam int FUNC_W  = 2;
    localparam int MASK_W  = 12;
    localparam int MODE_W  = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int PC_W    = 4;

    localparam logic [FUNC_W-1:0] FUNC_ON  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OFF = 2'd1;

    localparam logic [FUNC_W-1:0] KIND_ON    = 2'd0;
    localparam logic [FUNC_W-1:0] KIND_OFF   = 2'd1;
    localparam logic [FUNC_W-1:0] KIND_OTHER = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNAP_MODE  = 2'd1;

    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;

    localparam logic [MASK_W-1:0] SCALE_MASK_RESET = 12'hFFF;
    localparam logic [MODE_W-1:0] SNAP_MODE_RESET  = 2'd0;

    // Request token walking the held-note chain
    typedef struct packed {
        logic                active;
        logic                op_off;
        logic                done;
        logic [PITCH_W-1:0]  in_pitch;
        logic [PITCH_W-1:0]  out_pitch;
        logic [ID_W-1:0]     out_id;
    } nsq_tok_t;

endpackage

FILE: rtl/nsq_snap.sv
// Scale snap search: moves a pitch to the nearest permitted scale tone in the direction that the snap mode allows.
module nsq_snap (
    input  logic [nsq_pkg::PITCH_W-1:0] pitch,
    input  logic [nsq_pkg::MASK_W-1:0]  scale_mask,
    input  logic [nsq_pkg::MODE_W-1:0]  snap_mode,
    output logic [nsq_pkg::PITCH_W-1:0] snapped
);
    import nsq_pkg::*;

    logic [PC_W-1:0] pc0;
    logic [11:0]     dn_ok;
    logic [11:0]     up_ok;
    logic            mode_down;
    logic            mode_up;

    assign mode_down = (snap_mode == MODE_DOWN);
    assign mode_up   = snap_mode[1];

    // pitch modulo twelve by conditional subtraction
    always_comb begin
        logic [PITCH_W-1:0] r;
        r = pitch;
        if (r >= 7'd96) r = r - 7'd96;
        if (r >= 7'd48) r = r - 7'd48;
        if (r >= 7'd24) r = r - 7'd24;
        if (r >= 7'd12) r = r - 7'd12;
        pc0 = r[PC_W-1:0];
    end

    always_comb begin
        logic [PC_W-1:0] pc_dn;
        logic [PC_W-1:0] pc_up;
        logic [PC_W:0]   sum;
        for (int d = 0; d < 12; d++) begin
            pc_dn = (pc0 >= PC_W'(d)) ? pc0 - PC_W'(d) : pc0 + PC_W'(12 - d);
            sum   = {1'b0, pc0} + (PC_W+1)'(d);
            pc_up = (sum >= 5'd12) ? PC_W'(sum - 5'd12) : sum[PC_W-1:0];
            dn_ok[d] = ({1'b0, pitch} >= 8'(d)) && !(mode_up && d != 0)
                       && scale_mask[pc_dn];
            up_ok[d] = (({1'b0, pitch} + 8'(d)) <= 8'd127) && !(mode_down && d != 0)
                       && scale_mask[pc_up];
        end
    end

    // lowest distance wins, the lower candidate first
    always_comb begin
        snapped = pitch;
        for (int d = 11; d >= 0; d--) begin
            if (up_ok[d]) snapped = pitch + PITCH_W'(d);
            if (dn_ok[d]) snapped = pitch - PITCH_W'(d);
        end
    end

endmodule

FILE: rtl/nsq_cell.sv
// One held-note slot of the chain; serves the passing request token.
module nsq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  nsq_pkg::nsq_tok_t tok_in,
    output nsq_pkg::nsq_tok_t tok_out
);
    import nsq_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [PITCH_W-1:0] in_pitch_reg;
    logic [PITCH_W-1:0] out_pitch_reg;
    logic [ID_W-1:0]    out_id_reg;
    nsq_tok_t           tok_reg;
    nsq_tok_t           tok_next;
    logic               hit_on;
    logic               hit_off;

    assign hit_on  = tok_in.active && !tok_in.op_off && !tok_in.done && !valid_reg;
    assign hit_off = tok_in.active && tok_in.op_off && !tok_in.done && valid_reg
                     && (in_pitch_reg == tok_in.in_pitch);

    always_comb begin
        valid_next = valid_reg;
        tok_next   = tok_in;
        if (hit_on) begin
            valid_next    = 1'b1;
            tok_next.done = 1'b1;
        end
        if (hit_off) begin
            valid_next         = 1'b0;
            tok_next.done      = 1'b1;
            tok_next.out_pitch = out_pitch_reg;
            tok_next.out_id    = out_id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_on) begin
            in_pitch_reg  <= tok_in.in_pitch;
            out_pitch_reg <= tok_in.out_pitch;
            out_id_reg    <= tok_in.out_id;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/note_scale_quantizer.sv
// Top level of the note scale quantiser: control, configuration and held-note chain.
//
// For note-on and note-off requests the request token walks the chain of
// held-note slots one slot per cycle, and the next request is taken once its
// results are in the output register; other events bypass the chain. A
// note-on that finds every slot occupied gives a note-on followed by a
// matching note-off; a note-off with no matching held note gives no result.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
module note_scale_quantizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nsq_pkg::FUNC_W-1:0]      s_func,
    input  logic [nsq_pkg::PITCH_W-1:0]     s_pitch,
    input  logic [nsq_pkg::VEL_W-1:0]       s_velocity,
    input  logic [nsq_pkg::ID_W-1:0]        s_event_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nsq_pkg::FUNC_W-1:0]      m_out_kind,
    output logic [nsq_pkg::PITCH_W-1:0]     m_out_pitch,
    output logic [nsq_pkg::VEL_W-1:0]       m_out_velocity,
    output logic [nsq_pkg::ID_W-1:0]        m_out_id,
    output logic                            m_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nsq_pkg::MASK_W-1:0]      cfg_data
);
    import nsq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LAUNCH = 5'b00010,
        S_SCAN   = 5'b00100,
        S_EMIT   = 5'b01000,
        S_EMIT2  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [MASK_W-1:0]  scale_mask_reg, scale_mask_next;
    logic [MODE_W-1:0]  snap_mode_reg, snap_mode_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;

    logic               req_off_reg, req_off_next;
    logic [PITCH_W-1:0] req_pitch_reg, req_pitch_next;
    logic [VEL_W-1:0]   req_vel_reg, req_vel_next;

    logic [FUNC_W-1:0]  pend_kind_reg, pend_kind_next;
    logic [PITCH_W-1:0] pend_pitch_reg, pend_pitch_next;
    logic [VEL_W-1:0]   pend_vel_reg, pend_vel_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic               pend_last_reg, pend_last_next;
    logic               pend_two_reg, pend_two_next;

    logic               m_valid_reg, m_valid_next;
    logic [FUNC_W-1:0]  m_kind_reg, m_kind_next;
    logic [PITCH_W-1:0] m_pitch_reg, m_pitch_next;
    logic [VEL_W-1:0]   m_vel_reg, m_vel_next;
    logic [ID_W-1:0]    m_id_reg, m_id_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic [PITCH_W-1:0] snap_pitch;
    nsq_tok_t           tok_chain [0:HELD_ENTRIES];
    nsq_tok_t           tok_end;

    nsq_snap u_snap (
        .pitch      (req_pitch_reg),
        .scale_mask (scale_mask_reg),
        .snap_mode  (snap_mode_reg),
        .snapped    (snap_pitch)
    );

    assign tok_chain[0].active    = (state_reg == S_LAUNCH);
    assign tok_chain[0].op_off    = req_off_reg;
    assign tok_chain[0].done      = 1'b0;
    assign tok_chain[0].in_pitch  = req_pitch_reg;
    assign tok_chain[0].out_pitch = snap_pitch;
    assign tok_chain[0].out_id    = next_id_reg;

    for (genvar i = 0; i < HELD_ENTRIES; i++) begin : g_cell
        nsq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    assign tok_end   = tok_chain[HELD_ENTRIES];
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next      = state_reg;
        scale_mask_next = scale_mask_reg;
        snap_mode_next  = snap_mode_reg;
        next_id_next    = next_id_reg;
        req_off_next    = req_off_reg;
        req_pitch_next  = req_pitch_reg;
        req_vel_next    = req_vel_reg;
        pend_kind_next  = pend_kind_reg;
        pend_pitch_next = pend_pitch_reg;
        pend_vel_next   = pend_vel_reg;
        pend_id_next    = pend_id_reg;
        pend_last_next  = pend_last_reg;
        pend_two_next   = pend_two_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_pitch_next    = m_pitch_reg;
        m_vel_next      = m_vel_reg;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE_MASK: scale_mask_next = cfg_data;
                CFG_SNAP_MODE:  snap_mode_next  = cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_off_next   = (s_func == FUNC_OFF);
                    req_pitch_next = s_pitch;
                    req_vel_next   = s_velocity;
                    case (s_func)
                        FUNC_ON, FUNC_OFF: state_next = S_LAUNCH;
                        default: begin
                            pend_kind_next  = KIND_OTHER;
                            pend_pitch_next = s_pitch;
                            pend_vel_next   = s_velocity;
                            pend_id_next    = s_event_id;
                            pend_last_next  = 1'b1;
                            pend_two_next   = 1'b0;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_LAUNCH: begin
                if (!req_off_reg) next_id_next = next_id_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (tok_end.active) begin
                    pend_pitch_next = tok_end.out_pitch;
                    pend_id_next    = tok_end.out_id;
                    if (!req_off_reg) begin
                        pend_kind_next = KIND_ON;
                        pend_vel_next  = req_vel_reg;
                        pend_last_next = tok_end.done;
                        pend_two_next  = !tok_end.done;
                        state_next     = S_EMIT;
                    end else begin
                        pend_kind_next = KIND_OFF;
                        pend_vel_next  = '0;
                        pend_last_next = 1'b1;
                        pend_two_next  = 1'b0;
                        state_next     = tok_end.done ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_pitch_next = pend_pitch_reg;
                    m_vel_next   = pend_vel_reg;
                    m_id_next    = pend_id_reg;
                    m_last_next  = pend_last_reg;
                    state_next   = pend_two_reg ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_OFF;
                    m_pitch_next = pend_pitch_reg;
                    m_vel_next   = '0;
                    m_id_next    = pend_id_reg;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scale_mask_reg <= SCALE_MASK_RESET;
            snap_mode_reg  <= SNAP_MODE_RESET;
            next_id_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scale_mask_reg <= scale_mask_next;
            snap_mode_reg  <= snap_mode_next;
            next_id_reg    <= next_id_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_off_reg    <= req_off_next;
        req_pitch_reg  <= req_pitch_next;
        req_vel_reg    <= req_vel_next;
        pend_kind_reg  <= pend_kind_next;
        pend_pitch_reg <= pend_pitch_next;
        pend_vel_reg   <= pend_vel_next;
        pend_id_reg    <= pend_id_next;
        pend_last_reg  <= pend_last_next;
        pend_two_reg   <= pend_two_next;
        m_kind_reg     <= m_kind_next;
        m_pitch_reg    <= m_pitch_next;
        m_vel_reg      <= m_vel_next;
        m_id_reg       <= m_id_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_kind     = m_kind_reg;
    assign m_out_pitch    = m_pitch_reg;
    assign m_out_velocity = m_vel_reg;
    assign m_out_id       = m_id_reg;
    assign m_last         = m_last_reg;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for note_scale_quantizer: scale snapping, held-note table, pass-through.
module testbench;
    import nsq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [FUNC_W-1:0]      FUNC_OTHER   = 2'd2;
    localparam logic [FUNC_W-1:0]      FUNC_SPARE   = 2'd3;
    localparam logic [MODE_W-1:0]      MODE_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0]      MODE_UP      = 2'd2;
    localparam logic [MODE_W-1:0]      MODE_SPARE   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED   = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   velocity;
        logic [ID_W-1:0]    event_id;
    } note_req_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  kind;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   velocity;
        logic [ID_W-1:0]    voice;
        logic               last;
    } note_result_t;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [FUNC_W-1:0]      s_func         = '0;
    logic [PITCH_W-1:0]     s_pitch        = '0;
    logic [VEL_W-1:0]       s_velocity     = '0;
    logic [ID_W-1:0]        s_event_id     = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [FUNC_W-1:0]      m_out_kind;
    logic [PITCH_W-1:0]     m_out_pitch;
    logic [VEL_W-1:0]       m_out_velocity;
    logic [ID_W-1:0]        m_out_id;
    logic                   m_last;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [MASK_W-1:0]      cfg_data       = '0;

    // predicted block state
    logic [MASK_W-1:0]  cur_mask = SCALE_MASK_RESET;
    logic [MODE_W-1:0]  cur_mode = SNAP_MODE_RESET;
    logic               held_valid [HELD_ENTRIES];
    logic [PITCH_W-1:0] held_in_pitch [HELD_ENTRIES];
    logic [PITCH_W-1:0] held_out_pitch [HELD_ENTRIES];
    logic [ID_W-1:0]    held_voice [HELD_ENTRIES];
    logic [ID_W-1:0]    voice_counter = '0;

    note_req_t          pending_notes [$];
    note_result_t       expected_events [$];
    logic [PITCH_W-1:0] sounding_pitches [$];

    int in_sent       = 0;
    int in_taken      = 0;
    int cfg_taken     = 0;
    int n_results     = 0;
    int n_overflow    = 0;
    int n_unmatched   = 0;
    int n_errors      = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    note_scale_quantizer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pitch        (s_pitch),
        .s_velocity     (s_velocity),
        .s_event_id     (s_event_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_pitch    (m_out_pitch),
        .m_out_velocity (m_out_velocity),
        .m_out_id       (m_out_id),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        for (int i = 0; i < HELD_ENTRIES; i++) begin
            held_valid[i] = 1'b0;
        end
    end

    function automatic logic [PITCH_W-1:0] snap_to_scale(logic [PITCH_W-1:0] pitch);
        int note;
        int cand;
        logic [MODE_W-1:0] mode;
        note = pitch;
        mode = (cur_mode == MODE_SPARE) ? MODE_UP : cur_mode;
        for (int d = 0; d <= 11; d++) begin
            for (int k = 0; k < 2; k++) begin
                cand = (k == 0) ? note - d : note + d;
                if (mode == MODE_DOWN && cand > note) continue;
                if (mode == MODE_UP && cand < note) continue;
                if (cand < 0 || cand > 127) continue;
                if (cur_mask[cand % 12]) return cand[PITCH_W-1:0];
            end
        end
        return pitch;
    endfunction

    function automatic note_result_t make_result(logic [FUNC_W-1:0] kind,
            logic [PITCH_W-1:0] pitch, logic [VEL_W-1:0] velocity,
            logic [ID_W-1:0] voice, logic last);
        note_result_t r;
        r.kind     = kind;
        r.pitch    = pitch;
        r.velocity = velocity;
        r.voice    = voice;
        r.last     = last;
        return r;
    endfunction

    function automatic void quantise_event(note_req_t req);
        logic [PITCH_W-1:0] snapped;
        logic [ID_W-1:0]    voice;
        int                 slot;
        slot = -1;
        if (req.func == FUNC_ON) begin
            snapped = snap_to_scale(req.pitch);
            voice = voice_counter;
            voice_counter++;
            for (int i = 0; i < HELD_ENTRIES && slot < 0; i++) begin
                if (!held_valid[i]) slot = i;
            end
            if (slot >= 0) begin
                held_valid[slot]     = 1'b1;
                held_in_pitch[slot]  = req.pitch;
                held_out_pitch[slot] = snapped;
                held_voice[slot]     = voice;
                expected_events.push_back(make_result(KIND_ON, snapped, req.velocity, voice, 1'b1));
            end else begin
                n_overflow++;
                expected_events.push_back(make_result(KIND_ON, snapped, req.velocity, voice, 1'b0));
                expected_events.push_back(make_result(KIND_OFF, snapped, '0, voice, 1'b1));
            end
        end else if (req.func == FUNC_OFF) begin
            for (int i = 0; i < HELD_ENTRIES && slot < 0; i++) begin
                if (held_valid[i] && held_in_pitch[i] == req.pitch) slot = i;
            end
            if (slot >= 0) begin
                held_valid[slot] = 1'b0;
                expected_events.push_back(make_result(KIND_OFF, held_out_pitch[slot], '0,
                                                      held_voice[slot], 1'b1));
            end else begin
                n_unmatched++;
            end
        end else begin
            expected_events.push_back(make_result(KIND_OTHER, req.pitch, req.velocity,
                                                  req.event_id, 1'b1));
        end
    endfunction

    function automatic void log_error(string what, note_result_t want, note_result_t got);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $write("%s: expected kind %0d pitch %0d vel %0d id %0d last %0d, ",
                   what, want.kind, want.pitch, want.velocity, want.voice, want.last);
            $display("got kind %0d pitch %0d vel %0d id %0d last %0d",
                     got.kind, got.pitch, got.velocity, got.voice, got.last);
        end
    endfunction

    // keep a shadow of sounding pitches so note-offs can target held notes
    task automatic add_item(logic [FUNC_W-1:0] func, logic [PITCH_W-1:0] pitch,
                            logic [VEL_W-1:0] velocity, logic [ID_W-1:0] event_id);
        note_req_t req;
        int        hit;
        req.func     = func;
        req.pitch    = pitch;
        req.velocity = velocity;
        req.event_id = event_id;
        hit = -1;
        if (func == FUNC_ON && sounding_pitches.size() < HELD_ENTRIES) begin
            sounding_pitches.push_back(pitch);
        end else if (func == FUNC_OFF) begin
            for (int i = 0; i < sounding_pitches.size() && hit < 0; i++) begin
                if (sounding_pitches[i] == pitch) hit = i;
            end
            if (hit >= 0) sounding_pitches.delete(hit);
        end
        pending_notes.push_back(req);
    endtask

    function automatic logic [PITCH_W-1:0] pick_pitch();
        int r;
        r = $urandom_range(99);
        if (r < 10) return PITCH_W'($urandom_range(3));
        if (r < 20) return PITCH_W'($urandom_range(127, 124));
        return PITCH_W'($urandom_range(127));
    endfunction

    task automatic queue_random(int count, int on_pct);
        int                 r;
        int                 off_pct;
        logic [PITCH_W-1:0] pitch;
        logic [FUNC_W-1:0]  func;
        off_pct = (100 - on_pct) * 3 / 4;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < on_pct) begin
                func  = FUNC_ON;
                pitch = pick_pitch();
            end else if (r < on_pct + off_pct) begin
                func = FUNC_OFF;
                if (sounding_pitches.size() > 0 && $urandom_range(99) < 85) begin
                    pitch = sounding_pitches[$urandom_range(sounding_pitches.size() - 1)];
                end else begin
                    pitch = pick_pitch();
                end
            end else begin
                func  = ($urandom_range(3) == 0) ? FUNC_SPARE : FUNC_OTHER;
                pitch = pick_pitch();
            end
            add_item(func, pitch, VEL_W'($urandom_range(127)), ID_W'($urandom_range(65535)));
        end
    endtask

    task automatic wait_idle();
        while (pending_notes.size() != 0 || in_taken != in_sent || expected_events.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [MASK_W-1:0] data);
        int seen;
        seen = cfg_taken;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        while (cfg_taken == seen) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_scale(logic [MASK_W-1:0] mask, logic [MODE_W-1:0] mode);
        wait_idle();
        write_reg(CFG_SCALE_MASK, mask);
        write_reg(CFG_SNAP_MODE, MASK_W'(mode));
    endtask

    always @(negedge aclk) begin : driver
        note_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && in_taken < in_sent) begin
            // hold until accepted
        end else if (pending_notes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req = pending_notes.pop_front();
            in_sent++;
            s_valid    <= 1'b1;
            s_func     <= req.func;
            s_pitch    <= req.pitch;
            s_velocity <= req.velocity;
            s_event_id <= req.event_id;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : monitor
        note_result_t got;
        note_result_t want;
        note_req_t    req;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = make_result(m_out_kind, m_out_pitch, m_out_velocity, m_out_id, m_last);
                n_results++;
                if (expected_events.size() == 0) begin
                    log_error("unexpected result", '0, got);
                end else begin
                    want = expected_events.pop_front();
                    if (got !== want) log_error("mismatch", want, got);
                end
            end
            if (s_valid && s_ready) begin
                req.func     = s_func;
                req.pitch    = s_pitch;
                req.velocity = s_velocity;
                req.event_id = s_event_id;
                in_taken++;
                quantise_event(req);
            end
            if (cfg_valid && cfg_ready) begin
                cfg_taken++;
                if (cfg_index == CFG_SCALE_MASK)     cur_mask = cfg_data;
                else if (cfg_index == CFG_SNAP_MODE) cur_mode = cfg_data[MODE_W-1:0];
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 81;
        add_item(FUNC_ON, 7'd0, 7'd0, 16'h0000);
        add_item(FUNC_ON, 7'd127, 7'd127, 16'hFFFF);
        add_item(FUNC_ON, 7'd60, 7'd100, 16'h1234);
        add_item(FUNC_ON, 7'd60, 7'd1, 16'h4321);
        add_item(FUNC_OFF, 7'd60, 7'd5, 16'h0001);
        add_item(FUNC_OFF, 7'd60, 7'd5, 16'h0002);
        add_item(FUNC_OFF, 7'd60, 7'd5, 16'h0003);
        add_item(FUNC_OTHER, 7'd127, 7'd127, 16'hFFFF);
        add_item(FUNC_SPARE, 7'd0, 7'd0, 16'h0000);
        add_item(FUNC_OTHER, 7'd85, 7'd42, 16'hA5A5);
        add_item(FUNC_OFF, 7'd0, 7'd0, 16'h0000);
        add_item(FUNC_OFF, 7'd127, 7'd127, 16'hFFFF);
        add_item(FUNC_OFF, 7'd5, 7'd0, 16'h0000);

        set_scale(12'hAB5, MODE_NEAREST);
        queue_random(55, 45);
        set_scale(12'h041, MODE_NEAREST);
        add_item(FUNC_ON, 7'd3, 7'd64, 16'h0F0F);
        add_item(FUNC_ON, 7'd9, 7'd64, 16'hF0F0);
        queue_random(55, 45);
        set_scale(MASK_W'($urandom_range(4095)), MODE_DOWN);
        queue_random(55, 45);

        set_scale(12'h800, MODE_UP);
        write_reg(CFG_UNUSED, MASK_W'($urandom_range(4095)));
        send_idle_pct = 81;
        recv_idle_pct = 35;
        add_item(FUNC_ON, 7'd127, 7'd90, 16'h00FF);
        add_item(FUNC_ON, 7'd0, 7'd90, 16'hFF00);
        queue_random(55, 45);
        set_scale(12'h001, MODE_DOWN);
        add_item(FUNC_ON, 7'd0, 7'd33, 16'h1111);
        add_item(FUNC_ON, 7'd11, 7'd33, 16'h2222);
        queue_random(55, 45);
        set_scale(12'h000, MODE_SPARE);
        add_item(FUNC_ON, 7'd64, 7'd77, 16'h3333);
        queue_random(55, 45);

        set_scale(12'hFFF, MODE_NEAREST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(120, 92);
        set_scale(MASK_W'($urandom_range(4095)), MODE_SPARE);
        queue_random(55, 45);
        set_scale(MASK_W'($urandom_range(4095)), MODE_UP);
        queue_random(55, 45);
        wait_idle();

        $display("covered %0d requests and %0d results over %0d register writes",
                 in_taken, n_results, cfg_taken);
        $display("table overflows %0d, unmatched note-offs %0d, mismatches %0d",
                 n_overflow, n_unmatched, n_errors);
        if (n_errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
